// ----- design/ibwt_pkg.sv -----
// Shared types, widths and codes for the inverse BWT block decoder.
package ibwt_pkg;

    localparam int unsigned BLOCK_DEPTH = 4096;
    localparam int unsigned ADDR_W      = $clog2(BLOCK_DEPTH);
    localparam int unsigned LEN_W       = ADDR_W + 1;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned NUM_SYMBOLS = 256;
    localparam int unsigned SWEEP_W     = SYM_W + 1;

    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [1:0]        t_status;

    localparam t_len DEPTH_LEN = t_len'(BLOCK_DEPTH);

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Result status codes.
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_NONE     = 2'd1;
    localparam t_status STATUS_RANGE    = 2'd2;
    localparam t_status STATUS_OVERFLOW = 2'd3;

    // Error flag bit positions.
    localparam int unsigned FLAG_RANGE_BIT    = 0;
    localparam int unsigned FLAG_OVERFLOW_BIT = 1;

    // One entry of the block store: transformed symbol and its running rank.
    typedef struct packed {
        t_sym  sym;
        t_addr rank;
    } t_entry;

endpackage

// ----- design/ibwt_if.sv -----
// Valid/ready channel interfaces for commands and decoded results.
interface ibwt_cmd_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    ibwt_pkg::t_sym        symbol;
    logic                  last_in_block;
    ibwt_pkg::t_addr       start_index;

    modport source (output valid, command, symbol, last_in_block, start_index, input ready);
    modport sink   (input valid, command, symbol, last_in_block, start_index, output ready);
endinterface

interface ibwt_res_if;
    logic                  valid;
    logic                  ready;
    ibwt_pkg::t_sym        out_symbol;
    logic                  last_of_block;
    ibwt_pkg::t_status     status;

    modport source (output valid, out_symbol, last_of_block, status, input ready);
    modport sink   (input valid, out_symbol, last_of_block, status, output ready);
endinterface

// ----- design/inverse_bwt_block_decoder.sv -----
// Inverse Burrows-Wheeler block decoder built around a block store and a count memory.
//
// Usage: commands arrive on i_cmd. A load beat (command 0) appends one transformed
// byte to the block; the beat marked last_in_block also carries the primary index.
// A fetch beat (command 1) yields exactly one beat on o_res: the next decoded byte,
// or a status code when nothing is pending. Loads yield no result beat.
// A load reads its count, then writes the block store and the incremented count.
// A final load whose primary index is in range is followed by a prefix-sum sweep
// over the 256-entry count memory, during which i_cmd is not ready. A fetch with
// a walk pending reads the block store, then the count addressed by the fetched
// symbol, then forms the next walk position.
// Result beats sit in an output register; while the receiver stalls, one more
// finished result is parked and the command side waits until it can be handed on.
// Loads still proceed while a result waits in the output register.
// Reset (synchronous, active low) empties the output, clears block length, walk
// state and error flags, and marks every count entry invalid so it reads as zero.
// The block store is never cleared; the walk only reads entries of the current block.
module inverse_bwt_block_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ibwt_cmd_if.sink          i_cmd,
    ibwt_res_if.source        o_res
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_PFX    = 3'd2;
    localparam logic [2:0] ST_WALK_A = 3'd3;
    localparam logic [2:0] ST_WALK_B = 3'd4;
    localparam logic [2:0] ST_RES    = 3'd5;

    // Block store: symbol plus rank per loaded position.
    ibwt_pkg::t_entry entry_mem [ibwt_pkg::BLOCK_DEPTH];
    ibwt_pkg::t_entry r_ent_rdata;
    // Symbol counts, later the exclusive prefix sums.
    ibwt_pkg::t_len   cnt_mem [ibwt_pkg::NUM_SYMBOLS];
    ibwt_pkg::t_len   r_cnt_rdata;
    ibwt_pkg::t_sym   r_cnt_raddr;
    logic [ibwt_pkg::NUM_SYMBOLS-1:0] r_cnt_valid;

    logic [2:0]                   r_state;
    ibwt_pkg::t_len               r_len;
    ibwt_pkg::t_addr              r_walk;
    ibwt_pkg::t_len               r_remain;
    logic [1:0]                   r_flags;
    ibwt_pkg::t_sym               r_load_sym;
    logic                         r_load_last;
    ibwt_pkg::t_addr              r_load_start;
    logic [ibwt_pkg::SWEEP_W-1:0] r_pfx_cnt;
    ibwt_pkg::t_len               r_run;

    // Parked result while the output register is occupied.
    ibwt_pkg::t_sym    r_res_sym;
    logic              r_res_last;
    ibwt_pkg::t_status r_res_status;

    logic              r_out_valid;
    ibwt_pkg::t_sym    r_out_sym;
    logic              r_out_last;
    ibwt_pkg::t_status r_out_status;

    logic              cmd_fire;
    logic              out_free;
    ibwt_pkg::t_len    cnt_eff;
    ibwt_pkg::t_len    n_len;
    ibwt_pkg::t_len    walk_sum;
    ibwt_pkg::t_status none_status;

    logic              ent_we;
    ibwt_pkg::t_addr   ent_waddr;
    ibwt_pkg::t_entry  ent_wdata;
    logic              ent_re;
    ibwt_pkg::t_addr   ent_raddr;
    logic              cnt_we;
    ibwt_pkg::t_sym    cnt_waddr;
    ibwt_pkg::t_len    cnt_wdata;
    logic              cnt_re;
    ibwt_pkg::t_sym    cnt_raddr;

    logic              emit;
    ibwt_pkg::t_sym    emit_sym;
    logic              emit_last;
    ibwt_pkg::t_status emit_status;

    assign i_cmd.ready        = (r_state == ST_IDLE);
    assign cmd_fire           = i_cmd.valid && i_cmd.ready;
    assign out_free           = !r_out_valid || o_res.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.out_symbol    = r_out_sym;
    assign o_res.last_of_block = r_out_last;
    assign o_res.status        = r_out_status;

    // An entry never written in this block reads as zero.
    assign cnt_eff  = r_cnt_valid[r_cnt_raddr] ? r_cnt_rdata : '0;
    assign n_len    = r_len + ibwt_pkg::t_len'(1);
    assign walk_sum = ibwt_pkg::t_len'(r_ent_rdata.rank) + cnt_eff;

    always_comb begin
        if (r_flags[ibwt_pkg::FLAG_OVERFLOW_BIT]) begin
            none_status = ibwt_pkg::STATUS_OVERFLOW;
        end else if (r_flags[ibwt_pkg::FLAG_RANGE_BIT]) begin
            none_status = ibwt_pkg::STATUS_RANGE;
        end else begin
            none_status = ibwt_pkg::STATUS_NONE;
        end
    end

    // Memory port steering and result formation.
    always_comb begin
        ent_we      = 1'b0;
        ent_waddr   = r_len[ibwt_pkg::ADDR_W-1:0];
        ent_wdata   = '{sym: r_load_sym, rank: cnt_eff[ibwt_pkg::ADDR_W-1:0]};
        ent_re      = 1'b0;
        ent_raddr   = r_walk;
        cnt_we      = 1'b0;
        cnt_waddr   = r_load_sym;
        cnt_wdata   = cnt_eff + ibwt_pkg::t_len'(1);
        cnt_re      = 1'b0;
        cnt_raddr   = i_cmd.symbol;
        emit        = 1'b0;
        emit_sym    = '0;
        emit_last   = 1'b0;
        emit_status = ibwt_pkg::STATUS_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire && i_cmd.command == ibwt_pkg::CMD_LOAD) begin
                    cnt_re = (r_len < ibwt_pkg::DEPTH_LEN);
                end else if (cmd_fire) begin
                    if (r_remain == '0) begin
                        emit        = 1'b1;
                        emit_status = none_status;
                    end else begin
                        ent_re = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                ent_we = 1'b1;
                cnt_we = 1'b1;
            end
            ST_PFX: begin
                // Read entry k while entry k-1 receives the running sum.
                cnt_re    = !r_pfx_cnt[ibwt_pkg::SYM_W];
                cnt_raddr = r_pfx_cnt[ibwt_pkg::SYM_W-1:0];
                cnt_we    = (r_pfx_cnt != '0);
                cnt_waddr = r_cnt_raddr;
                cnt_wdata = r_run;
            end
            ST_WALK_A: begin
                cnt_re    = 1'b1;
                cnt_raddr = r_ent_rdata.sym;
            end
            ST_WALK_B: begin
                emit      = 1'b1;
                emit_sym  = r_ent_rdata.sym;
                emit_last = (r_remain == ibwt_pkg::t_len'(1));
            end
            ST_RES: begin
                emit        = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_rdata <= entry_mem[ent_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rdata <= cnt_mem[cnt_raddr];
            r_cnt_raddr <= cnt_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_walk      <= '0;
            r_remain    <= '0;
            r_flags     <= '0;
            r_cnt_valid <= '0;
            r_pfx_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (cmd_fire && i_cmd.command == ibwt_pkg::CMD_LOAD) begin
                        // Any pending walk is abandoned by a load.
                        r_remain     <= '0;
                        r_load_sym   <= i_cmd.symbol;
                        r_load_last  <= i_cmd.last_in_block;
                        r_load_start <= i_cmd.start_index;
                        if (r_len == '0) begin
                            r_cnt_valid <= '0;
                            r_flags     <= '0;
                        end
                        if (r_len < ibwt_pkg::DEPTH_LEN) begin
                            r_state <= ST_LOAD;
                        end else begin
                            // Block full: drop the byte, and a final drop arms nothing.
                            r_flags[ibwt_pkg::FLAG_OVERFLOW_BIT] <= 1'b1;
                            if (i_cmd.last_in_block) begin
                                r_len <= '0;
                            end
                        end
                    end else if (cmd_fire && r_remain != '0) begin
                        r_state <= ST_WALK_A;
                    end
                end
                ST_LOAD: begin
                    r_cnt_valid[r_load_sym] <= 1'b1;
                    r_len                   <= n_len;
                    r_state                 <= ST_IDLE;
                    if (r_load_last) begin
                        r_len <= '0;
                        if (ibwt_pkg::t_len'(r_load_start) >= n_len) begin
                            r_flags[ibwt_pkg::FLAG_RANGE_BIT] <= 1'b1;
                        end else begin
                            r_walk    <= r_load_start;
                            r_remain  <= n_len;
                            r_pfx_cnt <= '0;
                            r_run     <= '0;
                            r_state   <= ST_PFX;
                        end
                    end
                end
                ST_PFX: begin
                    r_pfx_cnt <= r_pfx_cnt + ibwt_pkg::SWEEP_W'(1);
                    if (r_pfx_cnt != '0) begin
                        r_run                    <= r_run + cnt_eff;
                        r_cnt_valid[r_cnt_raddr] <= 1'b1;
                    end
                    if (r_pfx_cnt[ibwt_pkg::SYM_W]) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WALK_A: begin
                    r_state <= ST_WALK_B;
                end
                ST_WALK_B: begin
                    r_remain <= r_remain - ibwt_pkg::t_len'(1);
                    if (walk_sum >= ibwt_pkg::DEPTH_LEN) begin
                        r_walk <= '0;
                    end else begin
                        r_walk <= walk_sum[ibwt_pkg::ADDR_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
                ST_RES: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (emit) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_state <= ST_RES;
                end
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (emit && out_free) begin
            r_out_sym    <= emit_sym;
            r_out_last   <= emit_last;
            r_out_status <= emit_status;
        end else if (r_state == ST_RES && out_free) begin
            r_out_sym    <= r_res_sym;
            r_out_last   <= r_res_last;
            r_out_status <= r_res_status;
        end
        if (emit && !out_free) begin
            r_res_sym    <= emit_sym;
            r_res_last   <= emit_last;
            r_res_status <= emit_status;
        end
    end

endmodule
